// ===== src/mrot_pkg.sv =====
// Shared types and constants for the matrix rotation unit.
package mrot_pkg;

   localparam int ELEM_W  = 16;
   localparam int DIM_W   = 4;
   localparam int ANGLE_W = 2;
   localparam int INDEX_W = 2;
   localparam int PROD_W  = 2 * DIM_W;

   localparam logic [ANGLE_W-1:0] ANGLE_90  = 2'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_180 = 2'd1;
   localparam logic [ANGLE_W-1:0] ANGLE_270 = 2'd2;
   localparam logic [ANGLE_W-1:0] ANGLE_BAD = 2'd3;

   localparam logic [INDEX_W-1:0] REG_ROW_COUNT  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_COL_COUNT  = 2'd1;
   localparam logic [INDEX_W-1:0] REG_ANGLE_CODE = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0]   rows;
      logic [DIM_W-1:0]   cols;
      logic [ANGLE_W-1:0] angle;
   } mrot_cfg_type;

   typedef struct packed {
      logic strobe;
      logic row_end;
      logic last;
      logic bad;
   } mrot_cmd_type;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_READ = 2'b10
   } mrot_state_type;

endpackage

// ===== src/mrot_store.sv =====
// Element store: one write port and one read port with registered read data.
module mrot_store import mrot_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [ELEM_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [ELEM_W-1:0] rd_data
);

   logic [ELEM_W-1:0] mem_ff [DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mrot_seq.sv =====
// Load counter, readout sequencer and rotated address generation.
module mrot_seq import mrot_pkg::*; #(
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  mrot_cfg_type cfg,
   output logic         busy,
   output logic         wr_en,
   output logic [AW-1:0] wr_addr,
   output logic         rd_en,
   output logic [AW-1:0] rd_addr,
   output mrot_cmd_type cmd
);

   mrot_state_type     state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   mrot_cmd_type       cmd_ff, cmd_in;
   logic [DIM_W-1:0]   rows_ff, rows_in;
   logic [DIM_W-1:0]   cols_ff, cols_in;
   logic [ANGLE_W-1:0] angle_ff, angle_in;
   logic [DIM_W-1:0]   outer_ff, outer_in;
   logic [DIM_W-1:0]   inner_ff, inner_in;

   logic [PROD_W-1:0]  total;
   logic               complete;
   logic [DIM_W-1:0]   n_outer, n_inner;
   logic               inner_last, outer_last;
   logic [DIM_W-1:0]   src_row, src_col;
   logic [PROD_W-1:0]  src_addr;

   assign total    = PROD_W'(cfg.rows) * PROD_W'(cfg.cols);
   assign complete = (PROD_W'(count_ff) + PROD_W'(1)) >= total;

   assign n_outer    = (angle_ff == ANGLE_180) ? rows_ff : cols_ff;
   assign n_inner    = (angle_ff == ANGLE_180) ? cols_ff : rows_ff;
   assign inner_last = inner_ff == (n_inner - DIM_W'(1));
   assign outer_last = outer_ff == (n_outer - DIM_W'(1));

   always_comb begin
      case (angle_ff)
         ANGLE_90: begin
            src_row = rows_ff - DIM_W'(1) - inner_ff;
            src_col = outer_ff;
         end
         ANGLE_180: begin
            src_row = rows_ff - DIM_W'(1) - outer_ff;
            src_col = cols_ff - DIM_W'(1) - inner_ff;
         end
         default: begin
            src_row = inner_ff;
            src_col = cols_ff - DIM_W'(1) - outer_ff;
         end
      endcase
   end

   assign src_addr = PROD_W'(src_row) * PROD_W'(cols_ff) + PROD_W'(src_col);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd_in   = '0;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      angle_in = angle_ff;
      outer_in = outer_ff;
      inner_in = inner_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (start) begin
               wr_en = 1'b1;
               if (complete) begin
                  count_in = '0;
                  if (cfg.angle == ANGLE_BAD) begin
                     cmd_in = '{strobe: 1'b1, row_end: 1'b1, last: 1'b1, bad: 1'b1};
                  end else begin
                     state_in = ST_READ;
                     rows_in  = cfg.rows;
                     cols_in  = cfg.cols;
                     angle_in = cfg.angle;
                     outer_in = '0;
                     inner_in = '0;
                  end
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ST_READ: begin
            rd_en          = 1'b1;
            cmd_in.strobe  = 1'b1;
            cmd_in.row_end = inner_last;
            cmd_in.last    = inner_last && outer_last;
            if (inner_last) begin
               inner_in = '0;
               if (outer_last) begin
                  state_in = ST_LOAD;
               end else begin
                  outer_in = outer_ff + DIM_W'(1);
               end
            end else begin
               inner_in = inner_ff + DIM_W'(1);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmd_ff   <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff  <= rows_in;
      cols_ff  <= cols_in;
      angle_ff <= angle_in;
      outer_ff <= outer_in;
      inner_ff <= inner_in;
   end

   assign busy    = state_ff == ST_READ;
   assign wr_addr = count_ff[AW-1:0];
   assign rd_addr = src_addr[AW-1:0];
   assign cmd     = cmd_ff;

   a_last_ends_row: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.last |-> cmd_ff.row_end && cmd_ff.strobe)
      else $error("last result without row end");

   a_bad_is_single: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.bad |-> cmd_ff.last && $past(state_ff) == ST_LOAD)
      else $error("error result not a single word after a load");

   a_read_strobes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> cmd_ff.strobe)
      else $error("readout cycle without a result");

   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !wr_en)
      else $error("store written during readout");

endmodule

// ===== src/matrix_rotate_90_180_270_unit.sv =====
// Top level of the matrix rotation unit: configuration registers, store and sequencer.
//
//   Channel   Ports                                   Handshake
//   request   req_element                             start high while busy low
//   response  rsp_out_element, rsp_row_end,           rsp_strobe, one cycle per word
//             rsp_last, rsp_bad_angle
//   config    csr_index, csr_data                     csr_wr_en, one cycle per write
//
// Each request word is written to the store while start is high. The word that completes
// rows times cols words starts a readout of rows times cols store reads, with each result
// in the cycle after its read; busy is high through the readout.
// A bad angle code gives one error word in the cycle after the completing request.
// Sync reset clears the load count and sequencer; config resets to 8x8, angle 90.
// The receiver cannot stall, so a readout never pauses.
module matrix_rotate_90_180_270_unit import mrot_pkg::*; #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [ELEM_W-1:0] req_element,
   output logic                     rsp_strobe,
   output logic signed [ELEM_W-1:0] rsp_out_element,
   output logic                     rsp_row_end,
   output logic                     rsp_last,
   output logic                     rsp_bad_angle,
   input  logic                     csr_wr_en,
   input  logic [INDEX_W-1:0]       csr_index,
   input  logic [DIM_W-1:0]         csr_data
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [DIM_W-1:0]   row_count_ff, row_count_in;
   logic [DIM_W-1:0]   col_count_ff, col_count_in;
   logic [ANGLE_W-1:0] angle_code_ff, angle_code_in;

   mrot_cfg_type      cfg;
   mrot_cmd_type      cmd;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [ELEM_W-1:0] rd_data;

   always_comb begin
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      angle_code_in = angle_code_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROW_COUNT:  row_count_in  = csr_data;
            REG_COL_COUNT:  col_count_in  = csr_data;
            REG_ANGLE_CODE: angle_code_in = csr_data[ANGLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= DIM_W'(8);
         col_count_ff  <= DIM_W'(8);
         angle_code_ff <= ANGLE_90;
      end else begin
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         angle_code_ff <= angle_code_in;
      end
   end

   always_comb begin
      if (row_count_ff == '0) begin
         cfg.rows = DIM_W'(1);
      end else if (row_count_ff > DIM_W'(MAX_ROWS)) begin
         cfg.rows = DIM_W'(MAX_ROWS);
      end else begin
         cfg.rows = row_count_ff;
      end
      if (col_count_ff == '0) begin
         cfg.cols = DIM_W'(1);
      end else if (col_count_ff > DIM_W'(MAX_COLS)) begin
         cfg.cols = DIM_W'(MAX_COLS);
      end else begin
         cfg.cols = col_count_ff;
      end
      cfg.angle = angle_code_ff;
   end

   mrot_seq #(
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .cfg     (cfg),
      .busy    (busy),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .cmd     (cmd)
   );

   mrot_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_element),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe      = cmd.strobe;
   assign rsp_out_element = cmd.bad ? '0 : rd_data;
   assign rsp_row_end     = cmd.row_end;
   assign rsp_last        = cmd.last;
   assign rsp_bad_angle   = cmd.bad;

endmodule
